### sv/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and key tables of the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int unsigned ROW_COUNT   = 4;
    localparam int unsigned DIGIT_COUNT = 4;

    localparam int unsigned ROW_W   = 2;
    localparam int unsigned COL_W   = 3;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned VALUE_W = 14;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] KEY_NONE   = 7'h00;
    localparam logic [CODE_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CODE_W-1:0] ASCII_ONE  = 7'h31;
    localparam logic [CODE_W-1:0] ASCII_NINE = 7'h39;
    localparam logic [CODE_W-1:0] ASCII_STAR = 7'h2A;
    localparam logic [CODE_W-1:0] ASCII_HASH = 7'h23;

    localparam logic [COL_W-1:0] COL_IDLE = 3'b111;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN0 = 2'd0,
        CFG_COLUMN1 = 2'd1,
        CFG_COLUMN2 = 2'd2,
        CFG_SETTLE  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        COL_FIRST  = 2'd0,
        COL_SECOND = 2'd1,
        COL_THIRD  = 2'd2,
        COL_NONE   = 2'd3
    } t_column;

    typedef struct packed {
        logic [ROW_W-1:0]   row_drive;
        logic               key_valid;
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] digit_value;
        logic [INDEX_W-1:0] digit_index;
    } t_result;

    // keys by row: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
    function automatic logic [CODE_W-1:0] key_ascii(logic [ROW_W-1:0] row, t_column col);
        logic [CODE_W-1:0] code;
        code = KEY_NONE;
        if (col != COL_NONE) begin
            if (row == 2'd3) begin
                unique case (col)
                    COL_FIRST:  code = ASCII_STAR;
                    COL_SECOND: code = ASCII_ZERO;
                    default:    code = ASCII_HASH;
                endcase
            end else begin
                code = ASCII_ONE + CODE_W'(row) * 7'd3 + CODE_W'(col);
            end
        end
        return code;
    endfunction

    function automatic logic [VALUE_W-1:0] power_of_ten(logic [1:0] exponent);
        logic [VALUE_W-1:0] p;
        unique case (exponent)
            2'd0:    p = 14'd1;
            2'd1:    p = 14'd10;
            2'd2:    p = 14'd100;
            default: p = 14'd1000;
        endcase
        return p;
    endfunction

endpackage

### sv/mks_if.sv
// ----------------------------------------------------------------------------
// mks_sample_if / mks_result_if
// Valid/ready channels for column samples and decoded key results.
// ----------------------------------------------------------------------------
interface mks_sample_if import mks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [COL_W-1:0] column_sample;

    modport source (output valid, output kind, output column_sample, input ready);
    modport sink   (input valid, input kind, input column_sample, output ready);
endinterface

interface mks_result_if import mks_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_drive;
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic [VALUE_W-1:0] digit_value;
    logic [INDEX_W-1:0] digit_index;

    modport source (output valid, output row_drive, output key_valid, output key_code,
                    output digit_value, output digit_index, input ready);
    modport sink   (input valid, input row_drive, input key_valid, input key_code,
                    input digit_value, input digit_index, output ready);
endinterface

### sv/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Row-by-row scan and debounce of a 4x3 keypad with digit weighting.
// ----------------------------------------------------------------------------
// One beat per clock: each accepted sample updates the scan state in the same
// cycle and its result appears in the output register on the next cycle. A new
// sample is taken whenever that register is empty or being drained, so the
// rate is set only by the single output register and downstream ready.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner import mks_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mks_sample_if.sink           i_sample,
    mks_result_if.source         o_result
);

    localparam logic [INDEX_W-1:0] DIGIT_MAX = INDEX_W'(DIGIT_COUNT);
    localparam logic [INDEX_W-1:0] LAST_POS  = INDEX_W'(DIGIT_COUNT - 1);

    // configuration
    logic [COL_W-1:0]   r_col0_pattern;
    logic [COL_W-1:0]   r_col1_pattern;
    logic [COL_W-1:0]   r_col2_pattern;
    logic [COUNT_W-1:0] r_settle_samples;

    // scan state
    logic [ROW_W-1:0]   r_active_row,  n_active_row;
    logic [COL_W-1:0]   r_settled [ROW_COUNT];
    logic               r_debouncing,  n_debouncing;
    logic [COL_W-1:0]   r_last_sample, n_last_sample;
    logic [COUNT_W-1:0] r_stable_count, n_stable_count;
    logic [INDEX_W-1:0] r_entry_index, n_entry_index;

    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               accept;
    logic               settle_we;
    logic [COUNT_W-1:0] count_next;
    t_column            column;
    logic [CODE_W-1:0]  key;
    logic [CODE_W-1:0]  digit;
    logic [VALUE_W-1:0] value;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col0_pattern   <= 3'd6;
            r_col1_pattern   <= 3'd5;
            r_col2_pattern   <= 3'd3;
            r_settle_samples <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COLUMN0: r_col0_pattern   <= i_cfg_data[COL_W-1:0];
                CFG_COLUMN1: r_col1_pattern   <= i_cfg_data[COL_W-1:0];
                CFG_COLUMN2: r_col2_pattern   <= i_cfg_data[COL_W-1:0];
                default:     r_settle_samples <= i_cfg_data;
            endcase
        end
    end

    // column 0 wins over 1, 1 over 2 when patterns coincide
    always_comb begin
        priority if (i_sample.column_sample == r_col0_pattern) column = COL_FIRST;
        else if (i_sample.column_sample == r_col1_pattern)     column = COL_SECOND;
        else if (i_sample.column_sample == r_col2_pattern)     column = COL_THIRD;
        else                                                   column = COL_NONE;
    end

    assign count_next = (i_sample.column_sample != r_last_sample) ? '0 :
                        (r_stable_count == '1) ? r_stable_count : r_stable_count + 1'b1;

    always_comb begin
        n_active_row   = r_active_row;
        n_debouncing   = r_debouncing;
        n_last_sample  = r_last_sample;
        n_stable_count = r_stable_count;
        n_entry_index  = r_entry_index;
        settle_we      = 1'b0;
        key            = KEY_NONE;
        digit          = '0;
        value          = '0;

        if (accept) begin
            if (i_sample.kind) begin
                n_entry_index = '0;
            end else if (!r_debouncing) begin
                if (i_sample.column_sample != r_settled[r_active_row]) begin
                    n_debouncing   = 1'b1;
                    n_last_sample  = i_sample.column_sample;
                    n_stable_count = '0;
                end else begin
                    n_active_row = r_active_row + 1'b1;
                end
            end else begin
                n_stable_count = count_next;
                n_last_sample  = i_sample.column_sample;
                if (count_next >= r_settle_samples) begin
                    n_debouncing = 1'b0;
                    settle_we    = 1'b1;
                    key          = key_ascii(r_active_row, column);
                    if (key != KEY_NONE && r_entry_index < DIGIT_MAX) begin
                        // '*' and '#' take a position but weigh nothing
                        if (key >= ASCII_ZERO && key <= ASCII_NINE) begin
                            digit = key - ASCII_ZERO;
                            value = VALUE_W'(digit) *
                                    power_of_ten(2'(LAST_POS - r_entry_index));
                        end
                        n_entry_index = r_entry_index + 1'b1;
                    end
                    n_active_row = r_active_row + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out.row_drive   = n_active_row;
        n_out.key_valid   = (key != KEY_NONE);
        n_out.key_code    = key;
        n_out.digit_value = value;
        n_out.digit_index = n_entry_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_row   <= '0;
            r_debouncing   <= 1'b0;
            r_last_sample  <= '0;
            r_stable_count <= '0;
            r_entry_index  <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_settled[i] <= COL_IDLE;
            end
        end else begin
            r_active_row   <= n_active_row;
            r_debouncing   <= n_debouncing;
            r_last_sample  <= n_last_sample;
            r_stable_count <= n_stable_count;
            r_entry_index  <= n_entry_index;
            if (settle_we) begin
                r_settled[r_active_row] <= i_sample.column_sample;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.row_drive   = r_out.row_drive;
    assign o_result.key_valid   = r_out.key_valid;
    assign o_result.key_code    = r_out.key_code;
    assign o_result.digit_value = r_out.digit_value;
    assign o_result.digit_index = r_out.digit_index;

    // an index reset beat always reports index zero
    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sample.kind) |=> (o_result.valid && o_result.digit_index == '0))
        else $error("index reset beat did not clear digit index");

    // no key means no code and no weight
    a_no_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.key_valid) |->
        (o_result.key_code == KEY_NONE && o_result.digit_value == '0))
        else $error("code or weight without a key");

    // a decoded key always closes the debounce window
    a_key_ends_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.key_valid) |-> !r_debouncing)
        else $error("key given while still debouncing");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_index <= DIGIT_MAX)
        else $error("digit index beyond digit count");

endmodule
